// File: rtl/core/hfr_pkg.sv
// Shared constants, types and the hex digit decode of the hex frame receiver.
package hfr_pkg;

   localparam int unsigned QueueDepth      = 4;
   localparam int unsigned QueuePtrWidth   = $clog2(QueueDepth);
   localparam int unsigned QueueCountWidth = $clog2(QueueDepth + 1);

   localparam logic [1:0] StatusOk            = 2'd0;
   localparam logic [1:0] StatusAddrMismatch  = 2'd1;
   localparam logic [1:0] StatusChecksumError = 2'd2;
   localparam logic [1:0] StatusBadLength     = 2'd3;

   localparam logic KindPayload = 1'b0;
   localparam logic KindStatus  = 1'b1;

   localparam logic [31:0] MinFrameLength = 32'd9;
   localparam logic [2:0]  LastHeaderPos  = 3'd7;

   localparam logic [7:0] CharDigitLow  = 8'd48;
   localparam logic [7:0] CharDigitHigh = 8'd57;
   localparam logic [7:0] CharUpperLow  = 8'd65;
   localparam logic [7:0] CharUpperHigh = 8'd70;
   localparam logic [7:0] CharLowerLow  = 8'd97;
   localparam logic [7:0] CharLowerHigh = 8'd102;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } byte_beat_type;

   // The letters A-F and a-f carry their value minus nine in the low nibble.
   function automatic logic [3:0] nib_value(input logic [7:0] c);
      logic [3:0] v;
      v = 4'd0;
      if (c >= CharDigitLow && c <= CharDigitHigh) begin
         v = c[3:0];
      end else if ((c >= CharUpperLow && c <= CharUpperHigh) ||
                   (c >= CharLowerLow && c <= CharLowerHigh)) begin
         v = c[3:0] + 4'd9;
      end
      return v;
   endfunction

endpackage

// File: rtl/core/hfr_channels.sv
// Valid/ready channel interfaces for the character input and the result output.
interface hfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;

   modport source (output valid, output char_in, input ready);
   modport sink   (input valid, input char_in, output ready);
endinterface

interface hfr_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  data_byte;
   logic [15:0] dest_address;
   logic [15:0] source_address;
   logic [31:0] frame_length;
   logic [1:0]  status;
   logic        last;

   modport source (output valid, output kind, output data_byte, output dest_address,
                   output source_address, output frame_length, output status,
                   output last, input ready);
   modport sink   (input valid, input kind, input data_byte, input dest_address,
                   input source_address, input frame_length, input status,
                   input last, output ready);
endinterface

// File: rtl/core/hex_frame_receiver_unit.sv
// Top level of the hex frame receiver: own-address register, front end, queue and parser.
//
//   channel   direction  beat contents
//   req_chan  in         char_in
//   rsp_chan  out        kind, data_byte, dest_address, source_address,
//                        frame_length, status, last
//   csr       in         own_address, written when csr_write_enable is high
//
// One character is taken every cycle while req_chan is ready; every second character
// completes a byte, queued and then parsed into the result register. Unless rsp_chan
// stalls, the parser handles one byte per cycle, so results can leave at one per cycle.
// Reset clears the nibble pairing, the four-byte queue, the frame position and the
// own address. When rsp_chan stalls, the result register holds its beat, the queue
// fills and req_chan then stalls only on characters that would complete a byte.
module hex_frame_receiver_unit
   import hfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data,
   hfr_req_if.sink     req_chan,
   hfr_rsp_if.source   rsp_chan
);

   logic [15:0]   own_address_ff;
   logic [15:0]   own_address_in;
   byte_beat_type front_beat;
   byte_beat_type queue_beat;
   logic          queue_space;
   logic          queue_pop;

   assign own_address_in = csr_write_enable ? csr_write_data : own_address_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff <= '0;
      end else begin
         own_address_ff <= own_address_in;
      end
   end

   hfr_nibble_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .queue_space (queue_space),
      .byte_beat   (front_beat)
   );

   hfr_byte_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_beat (front_beat),
      .space     (queue_space),
      .pop       (queue_pop),
      .pop_beat  (queue_beat)
   );

   hfr_frame_back u_back (
      .clock       (clock),
      .reset       (reset),
      .byte_beat   (queue_beat),
      .byte_pop    (queue_pop),
      .own_address (own_address_ff),
      .rsp         (rsp_chan)
   );

endmodule

// File: rtl/core/hfr_nibble_front.sv
// Front end: decodes hex characters and pairs nibbles into bytes for the queue.
module hfr_nibble_front
   import hfr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   hfr_req_if.sink       req,
   input  logic          queue_space,
   output byte_beat_type byte_beat
);

   logic       phase_ff;
   logic       phase_in;
   logic [3:0] high_ff;
   logic [3:0] high_in;
   logic [3:0] nib;
   logic       accept;

   assign req.ready = !phase_ff || queue_space;
   assign accept    = req.valid && req.ready;
   assign nib       = nib_value(req.char_in);

   always_comb begin
      phase_in        = phase_ff;
      high_in         = high_ff;
      byte_beat.valid = 1'b0;
      byte_beat.data  = {high_ff, nib};
      if (accept) begin
         if (!phase_ff) begin
            high_in  = nib;
            phase_in = 1'b1;
         end else begin
            byte_beat.valid = 1'b1;
            phase_in        = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      high_ff <= high_in;
   end

endmodule

// File: rtl/core/hfr_byte_queue.sv
// Short byte queue that decouples the nibble front end from the frame parser.
module hfr_byte_queue
   import hfr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  byte_beat_type push_beat,
   output logic          space,
   input  logic          pop,
   output byte_beat_type pop_beat
);

   logic [7:0]                 mem_ff [QueueDepth];
   logic [QueuePtrWidth-1:0]   wr_ptr_ff;
   logic [QueuePtrWidth-1:0]   wr_ptr_in;
   logic [QueuePtrWidth-1:0]   rd_ptr_ff;
   logic [QueuePtrWidth-1:0]   rd_ptr_in;
   logic [QueueCountWidth-1:0] count_ff;
   logic [QueueCountWidth-1:0] count_in;

   assign space          = count_ff != QueueCountWidth'(QueueDepth);
   assign pop_beat.valid = count_ff != '0;
   assign pop_beat.data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_beat.valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      unique case ({push_beat.valid, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_beat.valid) begin
         mem_ff[wr_ptr_ff] <= push_beat.data;
      end
   end

endmodule

// File: rtl/core/hfr_frame_back.sv
// Back end: parses frame bytes, checks address, length and checksum, registers results.
module hfr_frame_back
   import hfr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  byte_beat_type byte_beat,
   output logic          byte_pop,
   input  logic [15:0]   own_address,
   hfr_rsp_if.source     rsp
);

   logic [31:0] pos_ff;
   logic [31:0] pos_in;
   logic [15:0] dest_ff;
   logic [15:0] dest_in;
   logic [15:0] src_ff;
   logic [15:0] src_in;
   logic [31:0] len_ff;
   logic [31:0] len_in;
   logic [6:0]  sum_ff;
   logic [6:0]  sum_in;

   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic        rsp_kind_ff;
   logic [7:0]  rsp_data_ff;
   logic [15:0] rsp_dest_ff;
   logic [15:0] rsp_src_ff;
   logic [31:0] rsp_len_ff;
   logic [1:0]  rsp_status_ff;

   logic        out_free;
   logic        emit;
   logic        emit_kind;
   logic [1:0]  emit_status;
   logic [7:0]  b;
   logic        in_header;
   logic        mismatch;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign byte_pop  = byte_beat.valid && out_free;
   assign b         = byte_beat.data;
   assign in_header = pos_ff[31:3] == '0;
   assign mismatch  = dest_in != own_address;

   always_comb begin
      pos_in      = pos_ff;
      dest_in     = dest_ff;
      src_in      = src_ff;
      len_in      = len_ff;
      sum_in      = sum_ff;
      emit        = 1'b0;
      emit_kind   = KindPayload;
      emit_status = StatusOk;
      if (byte_pop) begin
         if (in_header) begin
            sum_in = (pos_ff[2:0] == 3'd0) ? b[6:0] : sum_ff + b[6:0];
            unique case (pos_ff[2:1])
               2'd0:    dest_in = {dest_ff[7:0], b};
               2'd1:    src_in  = {src_ff[7:0], b};
               default: len_in  = {len_ff[23:0], b};
            endcase
            if (pos_ff[2:0] == LastHeaderPos && len_in < MinFrameLength) begin
               emit        = 1'b1;
               emit_kind   = KindStatus;
               emit_status = mismatch ? StatusAddrMismatch : StatusBadLength;
               pos_in      = '0;
            end else begin
               pos_in = pos_ff + 32'd1;
            end
         end else if (pos_ff == len_ff - 32'd1) begin
            emit      = 1'b1;
            emit_kind = KindStatus;
            priority if (mismatch) begin
               emit_status = StatusAddrMismatch;
            end else if (b != {1'b0, sum_ff}) begin
               emit_status = StatusChecksumError;
            end else begin
               emit_status = StatusOk;
            end
            pos_in = '0;
         end else begin
            emit   = 1'b1;
            sum_in = sum_ff + b[6:0];
            pos_in = pos_ff + 32'd1;
         end
      end
      rsp_valid_in = out_free ? emit : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         dest_ff      <= '0;
         src_ff       <= '0;
         len_ff       <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         dest_ff      <= dest_in;
         src_ff       <= src_in;
         len_ff       <= len_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_kind_ff   <= emit_kind;
         rsp_data_ff   <= (emit_kind == KindStatus) ? 8'd0 : b;
         rsp_dest_ff   <= dest_in;
         rsp_src_ff    <= src_in;
         rsp_len_ff    <= len_in;
         rsp_status_ff <= emit_status;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.kind           = rsp_kind_ff;
   assign rsp.data_byte      = rsp_data_ff;
   assign rsp.dest_address   = rsp_dest_ff;
   assign rsp.source_address = rsp_src_ff;
   assign rsp.frame_length   = rsp_len_ff;
   assign rsp.status         = rsp_status_ff;
   assign rsp.last           = rsp_kind_ff;

   // A status beat always closes the frame, so the next byte starts a new header.
   a_status_restarts_frame : assert property (@(posedge clock) disable iff (reset)
      (emit && emit_kind == KindStatus) |=> (pos_ff == '0))
      else $error("frame position not cleared after a status beat");

   // The payload part of a frame is only reached with a length of at least nine.
   a_payload_needs_length : assert property (@(posedge clock) disable iff (reset)
      (pos_ff[31:3] != '0) |-> (len_ff >= MinFrameLength))
      else $error("payload position reached with a short frame length");

   // Payload beats carry an ok status and no data on status beats.
   a_beat_fields : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_kind_ff == KindPayload && rsp_status_ff == StatusOk) ||
                        (rsp_kind_ff == KindStatus && rsp_data_ff == 8'd0)))
      else $error("result beat fields inconsistent with its kind");

endmodule
